// ===== rtl/core/stpseq_pkg.sv =====
// Package for the stepper phase sequencer: command codes, register map,
// coil sequence tables and the iteration-count reciprocal constants.
// No dependencies.
package stpseq_pkg;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_START = 2'd1,
		CMD_STOP  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	localparam logic [3:0]  COILS_RELEASED   = 4'hF;
	localparam logic [15:0] PHASE_TICKS_RST  = 16'd20;
	localparam logic [15:0] ITER_MAX         = 16'hFFFF;
	localparam logic [15:0] HOLD_MAX         = 16'hFFFF;
	localparam logic        REG_PHASE_TICKS  = 1'b0;

	// floor(x / 45) = (x * RECIP_45) >> RECIP_SHIFT for every x below 2^23.
	localparam int          RECIP_SHIFT      = 29;
	localparam logic [23:0] RECIP_45         = 24'd11930465;
	localparam int          QUOT_W           = 17;

	localparam logic [2:0]  LAST_FULL        = 3'd3;
	localparam logic [2:0]  LAST_HALF        = 3'd7;

	typedef logic [3:0] coils_t;

	function automatic coils_t pattern_for(input logic half, input logic ccw,
			input logic [2:0] idx);
		coils_t full_cw [4];
		coils_t full_ccw [4];
		coils_t half_cw [8];
		coils_t half_ccw [8];
		coils_t res;
		full_cw  = '{4'hE, 4'hD, 4'hB, 4'h7};
		full_ccw = '{4'h7, 4'hB, 4'hD, 4'hE};
		half_cw  = '{4'hE, 4'hC, 4'hD, 4'h9, 4'hB, 4'h3, 4'h7, 4'h6};
		half_ccw = '{4'h6, 4'h7, 4'h3, 4'hB, 4'h9, 4'hD, 4'hC, 4'hE};
		if (half) begin
			res = ccw ? half_ccw[idx] : half_cw[idx];
		end else begin
			res = ccw ? full_ccw[idx[1:0]] : full_cw[idx[1:0]];
		end
		return res;
	endfunction

endpackage

// ===== rtl/core/stepper_phase_sequencer_top.sv =====
// Stepper phase sequencer top level: input stage, sequencer state, output word.
// Depends on stpseq_pkg.
//
// An accepted word is held in stage 1, then its result in the output register.
// Throughput: one word per cycle when output is free; set by the one state update per word.
// Reset (arst_n low): coils released (1111), no move, phase_ticks back to 20,
// both pipeline stages empty.
module stepper_phase_sequencer_top
	import stpseq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // half_step, counter_clockwise, degrees[15:0], zero pad
	input  logic [1:0]  s_axis_tuser,   // cmd
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata    // coils[3:0], busy_res, done_res, zero pad
);

	logic [15:0] phase_ticks_q;

	logic               valid_s1;
	cmd_t               cmd_s1;
	logic               half_s1;
	logic               ccw_s1;
	logic [QUOT_W-1:0]  quot_s1;

	logic [15:0] iter_left_q;
	logic [2:0]  phase_idx_q;
	logic [15:0] hold_q;
	logic        mode_half_q;
	logic        dir_ccw_q;
	coils_t      coil_q;
	logic        moving_q;

	logic        out_valid_q;
	logic [7:0]  out_data_q;

	logic        out_free;
	logic        advance;
	logic        accept;
	logic [21:0] angle_scaled;
	logic [45:0] product;

	logic [15:0] iter_left_d;
	logic [2:0]  phase_idx_d;
	logic [15:0] hold_d;
	logic        mode_half_d;
	logic        dir_ccw_d;
	coils_t      coil_d;
	logic        moving_d;
	logic        done_d;
	logic [15:0] iters_new;
	logic [15:0] hold_inc;
	logic [2:0]  last_idx;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_PHASE_TICKS) ? {16'd0, phase_ticks_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PHASE_TICKS_RST;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_PHASE_TICKS) begin
			phase_ticks_q <= pwdata[15:0];
		end
	end

	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign angle_scaled = s_axis_tdata[0] ? {1'b0, s_axis_tdata[17:2], 5'd0}
	                                      : {s_axis_tdata[17:2], 6'd0};
	assign product      = {24'd0, angle_scaled} * {22'd0, RECIP_45};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= cmd_t'(s_axis_tuser);
			half_s1 <= s_axis_tdata[0];
			ccw_s1  <= s_axis_tdata[1];
			quot_s1 <= product[RECIP_SHIFT +: QUOT_W];
		end
	end

	always_comb begin
		iter_left_d = iter_left_q;
		phase_idx_d = phase_idx_q;
		hold_d      = hold_q;
		mode_half_d = mode_half_q;
		dir_ccw_d   = dir_ccw_q;
		coil_d      = coil_q;
		moving_d    = moving_q;
		done_d      = 1'b0;
		iters_new   = quot_s1[QUOT_W-1] ? ITER_MAX : quot_s1[15:0];
		hold_inc    = (hold_q != HOLD_MAX) ? hold_q + 16'd1 : hold_q;
		last_idx    = mode_half_q ? LAST_HALF : LAST_FULL;
		case (cmd_s1)
			CMD_START: begin
				mode_half_d = half_s1;
				dir_ccw_d   = ccw_s1;
				phase_idx_d = 3'd0;
				hold_d      = 16'd0;
				iter_left_d = iters_new;
				if (iters_new == 16'd0) begin
					moving_d = 1'b0;
					done_d   = 1'b1;
				end else begin
					moving_d = 1'b1;
					coil_d   = pattern_for(half_s1, ccw_s1, 3'd0);
				end
			end
			CMD_STOP: begin
				coil_d      = COILS_RELEASED;
				moving_d    = 1'b0;
				iter_left_d = 16'd0;
				phase_idx_d = 3'd0;
				hold_d      = 16'd0;
			end
			CMD_TICK: begin
				if (moving_q) begin
					hold_d = hold_inc;
					if (hold_inc >= phase_ticks_q) begin
						hold_d = 16'd0;
						if (phase_idx_q >= last_idx) begin
							phase_idx_d = 3'd0;
							if (iter_left_q <= 16'd1) begin
								iter_left_d = 16'd0;
								moving_d    = 1'b0;
								done_d      = 1'b1;
							end else begin
								iter_left_d = iter_left_q - 16'd1;
							end
						end else begin
							phase_idx_d = phase_idx_q + 3'd1;
						end
						if (moving_d) begin
							coil_d = pattern_for(mode_half_q, dir_ccw_q, phase_idx_d);
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_left_q <= 16'd0;
			phase_idx_q <= 3'd0;
			hold_q      <= 16'd0;
			mode_half_q <= 1'b0;
			dir_ccw_q   <= 1'b0;
			coil_q      <= COILS_RELEASED;
			moving_q    <= 1'b0;
		end else if (advance) begin
			iter_left_q <= iter_left_d;
			phase_idx_q <= phase_idx_d;
			hold_q      <= hold_d;
			mode_half_q <= mode_half_d;
			dir_ccw_q   <= dir_ccw_d;
			coil_q      <= coil_d;
			moving_q    <= moving_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {2'b00, done_d, moving_d, coil_d};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// A completing word never reports the move as still running.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[5] |-> !m_axis_tdata[4])
		else $error("done and busy set together");

	// While a move runs some coil is always energised.
	a_moving_drives: assert property (@(posedge clk) disable iff (!arst_n)
		moving_q |-> coil_q != COILS_RELEASED)
		else $error("coils released during a move");

	// An idle sequencer has no iterations outstanding.
	a_idle_no_iters: assert property (@(posedge clk) disable iff (!arst_n)
		!moving_q |-> iter_left_q == 16'd0)
		else $error("iterations left while idle");

	// Full-step moves stay within the four-phase sequence.
	a_full_idx: assert property (@(posedge clk) disable iff (!arst_n)
		moving_q && !mode_half_q |-> phase_idx_q <= LAST_FULL)
		else $error("full-step phase index out of range");

	// The stage register only empties or moves on when the output can take it.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1)
		else $error("stage word lost while output stalled");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for stepper_phase_sequencer_top: drives start, tick, stop and
// NOP words, predicts the coil drive with its own sequencer model and checks it.
// Depends on stpseq_pkg and the RTL of the block.
module tb_top;
	import stpseq_pkg::*;

	typedef struct packed {
		logic [1:0]  cmd;
		logic        half;
		logic        ccw;
		logic [15:0] deg;
	} step_cmd_t;

	typedef struct packed {
		logic [3:0] coils;
		logic       busy;
		logic       done;
	} coil_word_t;

	// Coil patterns per phase, phase 0 in the lowest nibble.
	localparam logic [15:0] WAVE_CW  = 16'h7BDE;
	localparam logic [15:0] WAVE_CCW = 16'hEDB7;
	localparam logic [31:0] HALF_CW  = 32'h673B9DCE;
	localparam logic [31:0] HALF_CCW = 32'hECD9B376;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;   // half_step, counter_clockwise, degrees[15:0], zero pad
	logic [1:0]  s_axis_tuser;   // cmd
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;   // coils[3:0], busy_res, done_res, zero pad

	step_cmd_t   pending_cmds[$];
	coil_word_t  expected_words[$];
	step_cmd_t   next_cmd;
	coil_word_t  got_word;
	coil_word_t  want_word;
	logic        in_taken;
	logic        steady;
	int unsigned errors;
	int unsigned words_in;
	int unsigned words_out;
	int unsigned moves_done;

	// Sequencer shadow state
	logic [15:0] hold_ticks;
	logic [15:0] iters_left;
	logic [2:0]  phase_idx;
	logic [15:0] hold_cnt;
	logic        run_half;
	logic        run_ccw;
	logic [3:0]  coil_state;
	logic        running;

	stepper_phase_sequencer_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic int unsigned move_iterations(input logic half, input logic [15:0] deg);
		int unsigned q;
		q = half ? (32 * int'(deg)) / 45 : (64 * int'(deg)) / 45;
		return (q > 65535) ? 65535 : q;
	endfunction

	function automatic logic [3:0] coil_pattern(input logic half, input logic ccw,
			input logic [2:0] idx);
		logic [3:0] pat;
		if (half) begin
			pat = ccw ? HALF_CCW[idx * 4 +: 4] : HALF_CW[idx * 4 +: 4];
		end else begin
			pat = ccw ? WAVE_CCW[idx[1:0] * 4 +: 4] : WAVE_CW[idx[1:0] * 4 +: 4];
		end
		return pat;
	endfunction

	task automatic sequencer_reset();
		hold_ticks = PHASE_TICKS_RST;
		iters_left = '0;
		phase_idx  = '0;
		hold_cnt   = '0;
		run_half   = 1'b0;
		run_ccw    = 1'b0;
		coil_state = COILS_RELEASED;
		running    = 1'b0;
	endtask

	task automatic step_sequencer(input logic [1:0] cmd, input logic half, input logic ccw,
			input logic [15:0] deg);
		int unsigned iters;
		logic        done;
		logic [2:0]  last;
		done = 1'b0;
		case (cmd)
			CMD_START: begin
				run_half  = half;
				run_ccw   = ccw;
				iters     = move_iterations(half, deg);
				phase_idx = '0;
				hold_cnt  = '0;
				if (iters == 0) begin
					iters_left = '0;
					running    = 1'b0;
					done       = 1'b1;
				end else begin
					iters_left = iters[15:0];
					running    = 1'b1;
					coil_state = coil_pattern(run_half, run_ccw, 3'd0);
				end
			end
			CMD_STOP: begin
				coil_state = COILS_RELEASED;
				running    = 1'b0;
				iters_left = '0;
				phase_idx  = '0;
				hold_cnt   = '0;
			end
			CMD_TICK: begin
				if (running) begin
					if (hold_cnt != HOLD_MAX) begin
						hold_cnt = hold_cnt + 16'd1;
					end
					if (hold_cnt >= hold_ticks) begin
						last = run_half ? LAST_HALF : LAST_FULL;
						hold_cnt = '0;
						if (phase_idx >= last) begin
							phase_idx = '0;
							if (iters_left <= 16'd1) begin
								iters_left = '0;
								running    = 1'b0;
								done       = 1'b1;
							end else begin
								iters_left = iters_left - 16'd1;
							end
						end else begin
							phase_idx = phase_idx + 3'd1;
						end
						if (running) begin
							coil_state = coil_pattern(run_half, run_ccw, phase_idx);
						end
					end
				end
			end
			default: begin
			end
		endcase
		expected_words.push_back('{coils: coil_state, busy: running, done: done});
	endtask

	task automatic queue_cmd(input logic [1:0] cmd, input logic half, input logic ccw,
			input logic [15:0] deg);
		pending_cmds.push_back('{cmd: cmd, half: half, ccw: ccw, deg: deg});
	endtask

	task automatic queue_filler(input logic [1:0] cmd);
		queue_cmd(cmd, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			16'($urandom_range(0, 65535)));
	endtask

	task automatic queue_random_moves(input int budget);
		int          n;
		int          r;
		int          k;
		int          ticks;
		logic        half;
		logic        ccw;
		logic [15:0] deg;
		longint      need;
		n = $urandom_range(1, 3);
		for (k = 0; k < n; k++) begin
			queue_filler(CMD_TICK);
		end
		while (n < budget) begin
			half = 1'($urandom_range(0, 1));
			ccw  = 1'($urandom_range(0, 1));
			r    = $urandom_range(0, 99);
			if (r < 70) begin
				deg = 16'($urandom_range(0, 4));
			end else if (r < 85) begin
				deg = 16'($urandom_range(5, 40));
			end else begin
				deg = 16'($urandom_range(0, 65535));
			end
			queue_cmd(CMD_START, half, ccw, deg);
			need = longint'(move_iterations(half, deg)) * (half ? 8 : 4) *
				((hold_ticks == 0) ? 1 : hold_ticks);
			ticks = ((need > 70) ? 70 : int'(need)) + $urandom_range(0, 2);
			for (k = 0; k < ticks; k++) begin
				r = $urandom_range(0, 99);
				if (r < 4) begin
					queue_filler(CMD_STOP);
				end else if (r < 7) begin
					queue_filler(CMD_NOP);
				end else if (r < 9) begin
					queue_cmd(CMD_START, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						16'($urandom_range(0, 6)));
				end else begin
					queue_filler(CMD_TICK);
				end
			end
			n = n + 1 + ticks;
		end
	endtask

	task automatic wait_quiet();
		while (pending_cmds.size() != 0 || s_axis_tvalid || expected_words.size() != 0) begin
			@(posedge clk);
		end
		repeat (6) @(posedge clk);
	endtask

	task automatic write_hold_ticks(input logic [15:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_PHASE_TICKS, 2'b00};
		pwdata  <= {16'($urandom_range(0, 65535)), value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		hold_ticks = value;
	endtask

	// Input word driver
	always @(negedge clk) begin
		if (arst_n) begin
			m_axis_tready <= steady || ($urandom_range(0, 99) >= 19);
			if (!s_axis_tvalid || in_taken) begin
				if (pending_cmds.size() != 0 && (steady || $urandom_range(0, 99) >= 19)) begin
					next_cmd = pending_cmds.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser  <= next_cmd.cmd;
					s_axis_tdata  <= {6'd0, next_cmd.deg, next_cmd.ccw, next_cmd.half};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result checker and predictor
	always @(posedge clk) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= s_axis_tvalid && s_axis_tready;
			if (m_axis_tvalid && m_axis_tready) begin
				got_word = '{coils: m_axis_tdata[3:0], busy: m_axis_tdata[4],
					done: m_axis_tdata[5]};
				words_out++;
				if (got_word.done) begin
					moves_done++;
				end
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected result word coils %h busy %b done %b", $time,
						got_word.coils, got_word.busy, got_word.done);
					errors++;
				end else begin
					want_word = expected_words.pop_front();
					if (got_word !== want_word) begin
						$display("%0t: mismatch expected coils %h busy %b done %b, got coils %h busy %b done %b",
							$time, want_word.coils, want_word.busy, want_word.done,
							got_word.coils, got_word.busy, got_word.done);
						errors++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				words_in++;
				step_sequencer(s_axis_tuser, s_axis_tdata[0], s_axis_tdata[1],
					s_axis_tdata[17:2]);
			end
		end
	end

	initial begin
		int unsigned hold_settings[7];
		int          i;
		hold_settings = '{2, 1, 3, 0, 65535, 20, 7};
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = CMD_TICK;
		m_axis_tready = 1'b0;
		steady        = 1'b0;
		errors        = 0;
		words_in      = 0;
		words_out     = 0;
		moves_done    = 0;
		sequencer_reset();
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		write_hold_ticks(16'd1);
		queue_cmd(CMD_TICK, 1'b0, 1'b0, 16'h0000);
		queue_cmd(CMD_NOP, 1'b1, 1'b1, 16'hFFFF);
		queue_cmd(CMD_STOP, 1'b0, 1'b0, 16'h0000);
		queue_cmd(CMD_START, 1'b0, 1'b0, 16'd1);
		repeat (4) queue_cmd(CMD_TICK, 1'b1, 1'b1, 16'hFFFF);
		queue_cmd(CMD_TICK, 1'b0, 1'b0, 16'h0000);
		queue_cmd(CMD_START, 1'b1, 1'b1, 16'd2);
		repeat (8) queue_cmd(CMD_TICK, 1'b0, 1'b0, 16'h0000);
		queue_cmd(CMD_START, 1'b0, 1'b1, 16'd0);
		queue_cmd(CMD_START, 1'b1, 1'b0, 16'd1);
		queue_cmd(CMD_START, 1'b1, 1'b0, 16'hFFFF);
		queue_cmd(CMD_TICK, 1'b0, 1'b0, 16'h0000);
		queue_cmd(CMD_NOP, 1'b0, 1'b0, 16'h0000);
		queue_cmd(CMD_START, 1'b0, 1'b1, 16'hFFFF);
		queue_cmd(CMD_TICK, 1'b1, 1'b0, 16'h5555);
		queue_cmd(CMD_STOP, 1'b1, 1'b1, 16'hAAAA);
		queue_cmd(CMD_TICK, 1'b0, 1'b0, 16'h0000);
		wait_quiet();

		for (i = 0; i < 7; i++) begin
			write_hold_ticks(16'(hold_settings[i]));
			steady = (i == 1);
			queue_random_moves(35);
			wait_quiet();
		end
		steady = 1'b0;

		$display("Sent %0d command words and checked %0d result words, %0d of them ending a move.",
			words_in, words_out, moves_done);
		$display("Hold settings ran from 0 and 1 up to 65535, in both step modes and directions.");
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
